// ===== hw/rtl/brf_pkg.sv =====
// brf_pkg: command codes and fixed field widths for the byte ring fifo
// used by byte_ring_fifo_unit and its port checker; no dependencies
package brf_pkg;

	localparam int DATA_W  = 8;   // byte payload
	localparam int COUNT_W = 8;   // level and space fields, saturating
	localparam int CMD_W   = 2;

	typedef enum logic [CMD_W-1:0] {
		CMD_PUT   = 2'd0,
		CMD_GET   = 2'd1,
		CMD_PEEK  = 2'd2,
		CMD_CLEAR = 2'd3
	} cmd_t;

	typedef logic [DATA_W-1:0]  byte_t;
	typedef logic [COUNT_W-1:0] count_t;

	// output beat layout, highest bit first
	typedef struct packed {
		logic [4:0] pad;
		logic       is_full;
		logic       is_empty;
		count_t     space_left;
		count_t     level;
		byte_t      data_out;
		logic       accepted;
	} result_t;

endpackage

// ===== hw/rtl/brf_ram.sv =====
// brf_ram: simple dual port byte store, one write and one registered read
// uses brf_pkg for the byte type
module brf_ram #(
	parameter int DEPTH  = 256,
	parameter int ADDR_W = 8
) (
	input  logic                clk,
	input  logic                we,
	input  logic [ADDR_W-1:0]   waddr,
	input  brf_pkg::byte_t      wdata,
	input  logic                re,
	input  logic [ADDR_W-1:0]   raddr,
	output brf_pkg::byte_t      rdata
);

	brf_pkg::byte_t mem [DEPTH];
	brf_pkg::byte_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read register only moves when a read is issued
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== hw/rtl/byte_ring_fifo_unit.sv =====
// byte_ring_fifo_unit: command driven byte fifo over a ring of SLOTS bytes
// depends on brf_pkg and brf_ram
//
// usage
//   the slave channel takes one command per beat: s_axis_tuser carries the
//   command (put, get, peek, clear) and s_axis_tdata the byte for a put
//   every command gives exactly one result beat on the master channel: an
//   accepted flag, the byte for a successful get or peek (zero otherwise),
//   then level, free space, empty and full as they stand after the command
//   the ring keeps one slot unused, so at most SLOTS-1 bytes are held;
//   level and free space saturate at 255 for large rings
//   the result beat passes the middle stage and the output register before
//   it is offered; throughput is one command per cycle while the receiver
//   keeps up, set by the single write and single read port of the store
//   pointers are updated at the accepting edge, so a get right after a put
//   reads the slot that the put has written, with no forwarding needed
//   reset clears both pointers and the valid flags; the store itself is not
//   cleared, as no slot is read before a put has written it
//   when the receiver stalls, the result beat holds in the output register
//   and one further command is taken into the middle stage; after that
//   s_axis_tready drops until the output register drains
module byte_ring_fifo_unit #(
	parameter int SLOTS = 256
) (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] data_in
	input  logic [1:0]  s_axis_tuser,   // [1:0] command

	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [0] accepted, [8:1] data_out, [16:9] level, [24:17] space_left,
	// [25] is_empty, [26] is_full, [31:27] zero
	output logic [31:0] m_axis_tdata
);

	localparam int PTR_W  = (SLOTS > 2) ? $clog2(SLOTS) : 1;
	localparam int CNT_W  = PTR_W + 1;
	localparam int WIDE_W = (CNT_W > brf_pkg::COUNT_W) ? CNT_W : brf_pkg::COUNT_W;

	localparam logic [PTR_W-1:0]  LAST_PTR  = PTR_W'(SLOTS - 1);
	localparam logic [CNT_W-1:0]  SLOTS_CNT = CNT_W'(SLOTS);
	localparam logic [CNT_W-1:0]  LAST_CNT  = CNT_W'(SLOTS - 1);
	localparam logic [WIDE_W-1:0] SAT_MAX   = WIDE_W'((1 << brf_pkg::COUNT_W) - 1);

	// ring pointers
	logic [PTR_W-1:0] wptr_q, rptr_q;
	logic [PTR_W-1:0] wptr_inc, rptr_inc;

	// middle stage: command done, store read in flight
	logic valid_s1, ok_s1, rd_s1;

	// output register
	logic              m_valid_q;
	brf_pkg::result_t  result_q;

	logic              accept;
	logic              s1_adv;
	brf_pkg::cmd_t     cmd;
	logic              empty_now, full_now;
	logic              put_ok, get_ok, peek_ok, cmd_ok;
	brf_pkg::byte_t    rdata;

	// status from the current pointers
	logic [CNT_W-1:0]  lvl, space;
	logic [WIDE_W-1:0] lvl_w, space_w;
	brf_pkg::count_t   lvl_sat, space_sat;
	brf_pkg::result_t  result_d;

	function automatic logic [PTR_W-1:0] ring_inc(input logic [PTR_W-1:0] p);
		ring_inc = (p == LAST_PTR) ? '0 : p + PTR_W'(1);
	endfunction

	assign accept = s_axis_tvalid && s_axis_tready;
	assign s1_adv = !m_valid_q || m_axis_tready;
	assign s_axis_tready = !valid_s1 || s1_adv;

	assign cmd      = brf_pkg::cmd_t'(s_axis_tuser);
	assign wptr_inc = ring_inc(wptr_q);
	assign rptr_inc = ring_inc(rptr_q);
	assign empty_now = (wptr_q == rptr_q);
	assign full_now  = (wptr_inc == rptr_q);

	// command decode against the state before the command
	always_comb begin
		put_ok  = 1'b0;
		get_ok  = 1'b0;
		peek_ok = 1'b0;
		cmd_ok  = 1'b0;
		case (cmd)
			brf_pkg::CMD_PUT: begin
				put_ok = !full_now;
				cmd_ok = !full_now;
			end
			brf_pkg::CMD_GET: begin
				get_ok = !empty_now;
				cmd_ok = !empty_now;
			end
			brf_pkg::CMD_PEEK: begin
				peek_ok = !empty_now;
				cmd_ok  = !empty_now;
			end
			brf_pkg::CMD_CLEAR: begin
				cmd_ok = 1'b1;
			end
			default: begin
				cmd_ok = 1'b0;
			end
		endcase
	end

	// byte store: write at the head for a put, read at the tail for get/peek
	brf_ram #(
		.DEPTH  (SLOTS),
		.ADDR_W (PTR_W)
	) u_ram (
		.clk   (clk),
		.we    (accept && put_ok),
		.waddr (wptr_q),
		.wdata (s_axis_tdata),
		.re    (accept && (get_ok || peek_ok)),
		.raddr (rptr_q),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
		end else if (accept) begin
			if (cmd == brf_pkg::CMD_CLEAR) begin
				wptr_q <= '0;
				rptr_q <= '0;
			end else begin
				if (put_ok) begin
					wptr_q <= wptr_inc;
				end
				if (get_ok) begin
					rptr_q <= rptr_inc;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (s1_adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ok_s1 <= cmd_ok;
			rd_s1 <= get_ok || peek_ok;
		end
	end

	// pointers already hold the post-command values while the beat sits in
	// the middle stage, as any newer command only lands at the same edge
	always_comb begin
		if (wptr_q >= rptr_q) begin
			lvl = {1'b0, wptr_q} - {1'b0, rptr_q};
		end else begin
			lvl = {1'b0, wptr_q} + SLOTS_CNT - {1'b0, rptr_q};
		end
		space   = LAST_CNT - lvl;
		lvl_w   = WIDE_W'(lvl);
		space_w = WIDE_W'(space);
		lvl_sat   = (lvl_w > SAT_MAX)   ? '1 : lvl_w[brf_pkg::COUNT_W-1:0];
		space_sat = (space_w > SAT_MAX) ? '1 : space_w[brf_pkg::COUNT_W-1:0];

		result_d            = '0;
		result_d.accepted   = ok_s1;
		result_d.data_out   = rd_s1 ? rdata : '0;
		result_d.level      = lvl_sat;
		result_d.space_left = space_sat;
		result_d.is_empty   = (wptr_q == rptr_q);
		result_d.is_full    = (wptr_inc == rptr_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (s1_adv) begin
			m_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && valid_s1) begin
			result_q <= result_d;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = result_q;

endmodule

// ===== hw/rtl/brf_checker.sv =====
// brf_checker: port level assertions for byte_ring_fifo_unit
// uses brf_pkg for the result beat layout; bound to the top level below
module brf_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic [7:0]  s_axis_tdata,
	input logic [1:0]  s_axis_tuser,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [31:0] m_axis_tdata
);

	brf_pkg::result_t res;
	logic             in_beat;

	assign res     = brf_pkg::result_t'(m_axis_tdata);
	assign in_beat = s_axis_tvalid && s_axis_tready && (s_axis_tdata == s_axis_tdata);

	// a stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result beat changed while stalled");

	// empty ring reports no bytes held
	a_empty_level: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && res.is_empty |-> res.level == '0)
		else $error("empty with nonzero level");

	// full ring has no room left, and cannot also be empty
	a_full_space: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && res.is_full |-> res.space_left == '0 && !res.is_empty)
		else $error("full with space left or also empty");

	// rejected commands return no data
	a_zero_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !res.accepted |-> res.data_out == '0)
		else $error("rejected command returned data");

	// a clear taken while the output side is idle, with the receiver ready at
	// the next edge, then shows up as an accepted beat with an empty ring
	a_clear_empty: assert property (@(posedge clk) disable iff (!arst_n)
		in_beat && s_axis_tuser == brf_pkg::CMD_CLEAR && !m_axis_tvalid ##1 m_axis_tready
		|=> m_axis_tvalid && res.is_empty && res.accepted)
		else $error("clear did not report an empty ring");

endmodule

bind byte_ring_fifo_unit brf_checker u_brf_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tdata  (s_axis_tdata),
	.s_axis_tuser  (s_axis_tuser),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

// ===== dv/byte_ring_fifo_unit_checker.sv =====
`timescale 1ns / 100ps
// byte_ring_fifo_unit_checker: watches both stream channels of the byte ring fifo,
// keeps its own ring model, predicts every status beat and compares it field by field
// depends on brf_pkg
module byte_ring_fifo_unit_checker
	import brf_pkg::*;
#(
	parameter int SLOTS = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] data_in
	input  logic [1:0]  s_axis_tuser,   // [1:0] command
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [0] accepted, [8:1] data_out, [16:9] level, [24:17] space_left,
	// [25] is_empty, [26] is_full
	input  logic [31:0] m_axis_tdata,
	output int          mismatches,
	output int          outstanding
);

	byte_t   ring_mem [SLOTS];
	int      wr_idx;
	int      rd_idx;
	result_t due_status [$];
	int      bad_count = 0;
	int      status_beats = 0;

	assign mismatches = bad_count;

	function automatic int step_ptr(int p);
		return (p + 1 >= SLOTS) ? 0 : p + 1;
	endfunction

	function automatic count_t clip_count(int v);
		return (v > 255) ? count_t'(255) : count_t'(v);
	endfunction

	// applies one command to the model ring and returns the status it leaves
	function automatic result_t run_command(cmd_t cmd, byte_t din);
		result_t st;
		int      held;
		st = '0;
		case (cmd)
		CMD_PUT: begin
			if (step_ptr(wr_idx) != rd_idx) begin
				ring_mem[wr_idx] = din;
				wr_idx = step_ptr(wr_idx);
				st.accepted = 1'b1;
			end
		end
		CMD_GET: begin
			if (wr_idx != rd_idx) begin
				st.data_out = ring_mem[rd_idx];
				rd_idx = step_ptr(rd_idx);
				st.accepted = 1'b1;
			end
		end
		CMD_PEEK: begin
			if (wr_idx != rd_idx) begin
				st.data_out = ring_mem[rd_idx];
				st.accepted = 1'b1;
			end
		end
		default: begin
			wr_idx = 0;
			rd_idx = 0;
			st.accepted = 1'b1;
		end
		endcase
		held = (wr_idx >= rd_idx) ? wr_idx - rd_idx : SLOTS - rd_idx + wr_idx;
		st.level      = clip_count(held);
		st.space_left = clip_count(SLOTS - 1 - held);
		st.is_empty   = (wr_idx == rd_idx);
		st.is_full    = (step_ptr(wr_idx) == rd_idx);
		return st;
	endfunction

	task automatic report_mismatch(string field, int got, int want);
		if (bad_count < 100)
			$display("status beat %0d: %s got %0d want %0d", status_beats, field, got, want);
		bad_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		result_t got;
		result_t want;
		if (!arst_n) begin
			wr_idx = 0;
			rd_idx = 0;
			due_status.delete();
			outstanding <= 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				due_status.push_back(run_command(cmd_t'(s_axis_tuser), s_axis_tdata));
			if (m_axis_tvalid && m_axis_tready) begin
				got = m_axis_tdata;
				if (due_status.size() == 0) begin
					report_mismatch("unexpected beat", 1, 0);
				end else begin
					want = due_status.pop_front();
					if (got.accepted !== want.accepted)
						report_mismatch("accepted", got.accepted, want.accepted);
					if (got.data_out !== want.data_out)
						report_mismatch("data_out", got.data_out, want.data_out);
					if (got.level !== want.level)
						report_mismatch("level", got.level, want.level);
					if (got.space_left !== want.space_left)
						report_mismatch("space_left", got.space_left, want.space_left);
					if (got.is_empty !== want.is_empty)
						report_mismatch("is_empty", got.is_empty, want.is_empty);
					if (got.is_full !== want.is_full)
						report_mismatch("is_full", got.is_full, want.is_full);
				end
				status_beats++;
			end
			outstanding <= due_status.size();
		end
	end

endmodule

// ===== dv/byte_ring_fifo_unit_tb.sv =====
`timescale 1ns / 100ps
// byte_ring_fifo_unit_tb: command stimulus and verdict for byte_ring_fifo_unit
// depends on brf_pkg, byte_ring_fifo_unit and byte_ring_fifo_unit_checker
module byte_ring_fifo_unit_tb;
	import brf_pkg::*;

	localparam int RING_SLOTS = 256;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = '0;   // [7:0] data_in
	logic [1:0]  s_axis_tuser = '0;   // [1:0] command
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	// [0] accepted, [8:1] data_out, [16:9] level, [24:17] space_left,
	// [25] is_empty, [26] is_full, [31:27] zero
	logic [31:0] m_axis_tdata;

	// sender to receiver hints: one long hold-off, and a window with no idling
	logic        hold_req = 1'b0;
	logic        calm = 1'b0;

	int          fail_count;
	int          outstanding;

	byte_ring_fifo_unit #(
		.SLOTS(RING_SLOTS)
	) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

	byte_ring_fifo_unit_checker #(
		.SLOTS(RING_SLOTS)
	) i_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.mismatches   (fail_count),
		.outstanding  (outstanding)
	);

	// 4 ns clock
	initial begin
		forever #2 clk = ~clk;
	end

	// reset held low from the start, released once and never again
	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
	end

	// hard stop, far beyond the slowest correct run
	initial begin
		#(2_000_000);
		$display("byte_ring_fifo_unit: mismatch");
		$finish;
	end

	// receiver: random back-pressure, one long hold-off on request so the
	// pipeline fills and s_axis_tready drops, and no stalls while calm is set
	initial begin : receiver
		int hold_left;
		bit hold_done;
		hold_left = 0;
		hold_done = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req && !hold_done) begin
				hold_left = 80;
				hold_done = 1'b1;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else if (calm) begin
				m_axis_tready <= 1'b1;
			end else begin
				m_axis_tready <= ($urandom_range(99) >= 21);
			end
		end
	end

	// offers one command beat and returns at the edge that takes it; valid is
	// left high so a following beat can go out back to back
	task automatic send_cmd(input cmd_t cmd, input byte_t din);
		if (!calm) begin
			while ($urandom_range(99) < 21) begin
				s_axis_tvalid <= 1'b0;
				@(posedge clk);
			end
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= cmd;
		s_axis_tdata  <= din;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
	endtask

	// sender goes quiet until every status beat has come back
	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
	endtask

	// weighted command pick: a little clear, put_pct put, the rest mostly get
	function automatic cmd_t pick_cmd(int put_pct);
		int r;
		int get_cut;
		r = $urandom_range(99);
		get_cut = 2 + put_pct + ((98 - put_pct) * 3) / 4;
		if (r < 2)
			return CMD_CLEAR;
		else if (r < 2 + put_pct)
			return CMD_PUT;
		else if (r < get_cut)
			return CMD_GET;
		return CMD_PEEK;
	endfunction

	initial begin : sender
		int put_pct;
		@(posedge arst_n);
		@(posedge clk);

		// directed: empty-ring rejects, byte extremes, peek versus get, clear
		// with bytes held, data ignored on non-put commands
		send_cmd(CMD_GET,   8'h00);
		send_cmd(CMD_PEEK,  8'hFF);
		send_cmd(CMD_CLEAR, 8'h00);
		send_cmd(CMD_PUT,   8'h00);
		send_cmd(CMD_PUT,   8'hFF);
		send_cmd(CMD_PUT,   8'hA5);
		send_cmd(CMD_PUT,   8'h5A);
		send_cmd(CMD_PEEK,  8'h11);
		send_cmd(CMD_GET,   8'hFF);
		send_cmd(CMD_GET,   8'h00);
		send_cmd(CMD_PEEK,  8'h00);
		send_cmd(CMD_CLEAR, 8'hFF);
		send_cmd(CMD_GET,   8'h00);
		send_cmd(CMD_PEEK,  8'h00);
		send_cmd(CMD_PUT,   8'h81);
		send_cmd(CMD_GET,   8'h7E);
		send_cmd(CMD_GET,   8'h00);
		send_cmd(CMD_PUT,   8'h7E);
		send_cmd(CMD_CLEAR, 8'h3C);
		send_cmd(CMD_PUT,   8'h01);
		send_cmd(CMD_PUT,   8'h80);
		send_cmd(CMD_GET,   8'h00);
		wait_drained();

		// fill past the top: the ring goes full and extra puts are refused
		for (int n = 0; n < 258; n++)
			send_cmd(CMD_PUT, byte_t'($urandom));
		send_cmd(CMD_PEEK, byte_t'($urandom));
		send_cmd(CMD_GET,  byte_t'($urandom));
		send_cmd(CMD_PUT,  byte_t'($urandom));
		send_cmd(CMD_PUT,  byte_t'($urandom));
		send_cmd(CMD_CLEAR, byte_t'($urandom));
		for (int n = 0; n < 258; n++)
			send_cmd(CMD_PUT, byte_t'($urandom));

		// drain to empty and beyond, with the odd peek on the way
		for (int n = 0; n < 300; n++)
			send_cmd(($urandom_range(9) == 0) ? CMD_PEEK : CMD_GET, byte_t'($urandom));
		wait_drained();

		// mixed traffic in long blocks of random bias, so the level wanders
		// between empty and full; one long receiver hold-off early on and a
		// calm window later
		put_pct = 50;
		for (int n = 0; n < 460; n++) begin
			if (n % 120 == 0)
				put_pct = $urandom_range(20, 80);
			if (n == 100)
				hold_req <= 1'b1;
			if (n == 250)
				calm <= 1'b1;
			if (n == 400)
				calm <= 1'b0;
			send_cmd(pick_cmd(put_pct), byte_t'($urandom));
		end

		wait_drained();
		repeat (8) @(posedge clk);
		if (fail_count == 0)
			$display("byte_ring_fifo_unit: match");
		else
			$display("byte_ring_fifo_unit: mismatch");
		$finish;
	end

endmodule

// ===== byte_ring_fifo_unit.f =====
hw/rtl/brf_pkg.sv
hw/rtl/brf_ram.sv
hw/rtl/byte_ring_fifo_unit.sv
hw/rtl/brf_checker.sv
dv/byte_ring_fifo_unit_checker.sv
dv/byte_ring_fifo_unit_tb.sv
